// File: design/pwsm_pkg.sv
// ----------------------------------------------------------------------------
// pwsm_pkg
// shared types and codes of the prefetch window slot manager
// ----------------------------------------------------------------------------
package pwsm_pkg;

  localparam int SLOT_W     = 5;
  localparam int SIZE_W     = 6;
  localparam int LOOK_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [SIZE_W-1:0] SLOTS_RESET_C = SIZE_W'(32);
  localparam logic [LOOK_W-1:0] LOOK_RESET_C  = LOOK_W'(1);

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_PRELOAD = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_UNLOAD = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_OK              = 3'd0,
    ERR_BAD_START       = 3'd1,
    ERR_BACKWARD        = 3'd2,
    ERR_PRELOAD_STARTED = 3'd3,
    ERR_PRELOAD_BUSY    = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY     = 2'd0,
    SLOT_LOADING   = 2'd1,
    SLOT_LOADED    = 2'd2,
    SLOT_UNLOADING = 2'd3
  } slot_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOTS     = 2'd0,
    CFG_LOOKAHEAD = 2'd1,
    CFG_TWO_PASS  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DECODE,
    FSM_MAIN,
    FSM_PREFETCH,
    FSM_UNLOAD,
    FSM_SWEEP,
    FSM_FINISH
  } fsm_e;

  // where the decode step sends the transaction
  typedef enum logic [1:0] {
    DEC_FINISH,
    DEC_MAIN,
    DEC_SWEEP
  } dec_e;

  typedef struct packed {
    logic capture;
    logic decode;
    logic main;
    logic prefetch;
    logic unload;
    logic sweep;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    dec_e dec;
    logic scan_done;
    logic scan_abort;
  } dp_status_t;

  typedef struct packed {
    cmd_e              command;
    logic [SLOT_W-1:0] slot;
    err_e              err;
    logic              w1;
    logic              w2;
  } result_t;

endpackage

// File: design/pwsm_ctrl.sv
// ----------------------------------------------------------------------------
// pwsm_ctrl
// sequencer of the slot manager: steps each transaction through its phases
// ----------------------------------------------------------------------------
module pwsm_ctrl import pwsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output logic       busy_o,
  output ctrl_cmd_t  cmd_o
);

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (start_i) begin
          state_d = FSM_DECODE;
        end
      end
      FSM_DECODE: begin
        unique case (status_i.dec)
          DEC_MAIN:  state_d = FSM_MAIN;
          DEC_SWEEP: state_d = FSM_SWEEP;
          default:   state_d = FSM_FINISH;
        endcase
      end
      FSM_MAIN: state_d = FSM_PREFETCH;
      FSM_PREFETCH: begin
        if (status_i.scan_done) begin
          state_d = FSM_UNLOAD;
        end
      end
      FSM_UNLOAD: state_d = FSM_FINISH;
      FSM_SWEEP: begin
        if (status_i.scan_done || status_i.scan_abort) begin
          state_d = FSM_FINISH;
        end
      end
      FSM_FINISH: state_d = FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy_o         = (state_q != FSM_IDLE);
    cmd_o          = '0;
    cmd_o.capture  = (state_q == FSM_IDLE) && start_i;
    cmd_o.decode   = (state_q == FSM_DECODE);
    cmd_o.main     = (state_q == FSM_MAIN);
    cmd_o.prefetch = (state_q == FSM_PREFETCH);
    cmd_o.unload   = (state_q == FSM_UNLOAD);
    cmd_o.sweep    = (state_q == FSM_SWEEP);
    cmd_o.finish   = (state_q == FSM_FINISH);
  end

endmodule

// File: design/pwsm_dp.sv
// ----------------------------------------------------------------------------
// pwsm_dp
// datapath of the slot manager: slot states, sweep state, scan and results
// ----------------------------------------------------------------------------
module pwsm_dp import pwsm_pkg::*; #(
  parameter int MAX_SLOTS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  input  logic [1:0]        operation_i,
  input  logic [SLOT_W-1:0] slot_index_i,
  input  logic              preload_downward_i,
  input  logic [SIZE_W-1:0] cfg_slots_i,
  input  logic [LOOK_W-1:0] cfg_lookahead_i,
  input  logic              cfg_two_pass_i,
  output dp_status_t        status_o,
  output logic              res_valid_o,
  output result_t           res_o,
  output logic              res_last_o
);

  localparam int IW  = $clog2(MAX_SLOTS);
  localparam int SCW = $clog2(MAX_SLOTS + 1);
  localparam int PW  = SCW + 1;
  localparam int CW  = ((SCW > SLOT_W) ? SCW : SLOT_W) + 2;

  localparam logic signed [CW-1:0] ZERO_C   = CW'(0);
  localparam logic signed [CW-1:0] ONE_C    = CW'(1);
  localparam logic signed [CW-1:0] MINUS1_C = CW'(-1);
  localparam logic signed [CW-1:0] MAX_C    = CW'(MAX_SLOTS);

  // transaction fields
  op_e               op_q;
  logic [SLOT_W-1:0] n_q;
  logic              down_q;

  // sweep state
  logic              started_q;
  logic              desc_q;
  logic [PW-1:0]     prev_q;
  slot_e             st_q [MAX_SLOTS];

  // scan unit
  logic [IW-1:0]     cur_q;
  logic [SCW-1:0]    rem_q;
  logic              scan_live;
  slot_e             cur_st;

  logic              w1_q, w2_q;

  // result staging: one held back so the last one can be marked
  logic              pend_valid_q;
  result_t           pend_q;
  logic              res_valid_q;
  result_t           res_q;
  logic              res_last_q;

  logic [SCW-1:0]    s_eff;
  logic signed [CW-1:0] s_c, n_c, la_c, prev_c;
  logic [IW-1:0]     n_idx, prev_idx;

  logic              err1, err2, bad, eff_desc;
  err_e              dec_err;
  dec_e              dec;
  logic signed [CW-1:0] cur_init, rem_init, room, la1;

  slot_e             st_n;
  logic              main_w1, main_w2;
  logic              unload_ok;

  logic              emit_vld;
  result_t           emit_res;
  logic              st_we;
  logic [IW-1:0]     st_waddr;
  slot_e             st_wdata;

  function automatic logic signed [CW-1:0] preload_dir_top(input logic down,
                                                           input logic signed [CW-1:0] s);
    return down ? (s - ONE_C) : ZERO_C;
  endfunction

  // effective slot count, clamped to 1..MAX_SLOTS
  always_comb begin
    if (cfg_slots_i == '0) begin
      s_eff = SCW'(1);
    end else if (cfg_slots_i > SIZE_W'(MAX_SLOTS)) begin
      s_eff = SCW'(MAX_SLOTS);
    end else begin
      s_eff = SCW'(cfg_slots_i);
    end
  end

  assign s_c      = $signed(CW'(s_eff));
  assign n_c      = $signed(CW'(n_q));
  assign la_c     = $signed(CW'(cfg_lookahead_i));
  assign prev_c   = CW'($signed(prev_q));
  assign n_idx    = IW'(n_q);
  assign prev_idx = IW'(prev_q);

  // decode checks
  always_comb begin
    err1     = (n_c >= s_c) || (!started_q && (n_c != ZERO_C) && (n_c != s_c - ONE_C));
    eff_desc = started_q ? desc_q : (n_c != ZERO_C);
    if (!desc_q) begin
      bad = (n_c < prev_c + ONE_C) && !(cfg_two_pass_i && (n_c == ZERO_C));
    end else begin
      bad = (n_c > prev_c - ONE_C) && !(cfg_two_pass_i && (n_c == s_c - ONE_C));
    end
    err2     = started_q && bad;
    room     = s_c - ONE_C - n_c;
    la1      = la_c + ONE_C;
    dec_err  = ERR_OK;
    dec      = DEC_FINISH;
    cur_init = ZERO_C;
    rem_init = ZERO_C;
    unique case (op_q)
      OP_REQUEST: begin
        if (err1) begin
          dec_err = ERR_BAD_START;
        end else if (err2) begin
          dec_err = ERR_BACKWARD;
        end else begin
          dec = DEC_MAIN;
        end
        if (eff_desc) begin
          cur_init = n_c - ONE_C;
          rem_init = (la_c < n_c) ? la_c : n_c;
        end else begin
          cur_init = n_c + ONE_C;
          rem_init = (la_c < room) ? la_c : room;
        end
      end
      OP_PRELOAD: begin
        if (started_q) begin
          dec_err = ERR_PRELOAD_STARTED;
        end else begin
          dec = DEC_SWEEP;
        end
        cur_init = preload_dir_top(down_q, s_c);
        rem_init = (la1 < s_c) ? la1 : s_c;
      end
      OP_CLEAR: begin
        if (started_q && cfg_two_pass_i) begin
          dec = DEC_SWEEP;
        end
        cur_init = preload_dir_top(desc_q, s_c);
        rem_init = s_c;
      end
      OP_NONE: begin
        dec = DEC_FINISH;
      end
    endcase
  end

  // scan and unload checks
  assign scan_live = (rem_q != '0);
  assign cur_st    = st_q[cur_q];
  assign st_n      = st_q[n_idx];
  assign main_w1   = (st_n == SLOT_UNLOADING);
  assign main_w2   = (st_n == SLOT_UNLOADING) || (st_n == SLOT_EMPTY);

  always_comb begin
    if (!desc_q) begin
      unload_ok = (prev_c != MINUS1_C) && !(cfg_two_pass_i && (n_c > s_c - la_c));
    end else begin
      unload_ok = (prev_c != s_c) && !(cfg_two_pass_i && (n_c < la_c));
    end
    unload_ok = unload_ok && (prev_c >= ZERO_C) && (prev_c < MAX_C);
  end

  assign status_o.dec        = dec;
  assign status_o.scan_done  = (rem_q <= SCW'(1));
  assign status_o.scan_abort = (op_q == OP_PRELOAD) && scan_live && (cur_st != SLOT_EMPTY);

  // result and slot write of the current phase
  always_comb begin
    emit_vld         = 1'b0;
    emit_res.command = CMD_NONE;
    emit_res.slot    = '0;
    emit_res.err     = ERR_OK;
    emit_res.w1      = w1_q;
    emit_res.w2      = w2_q;
    st_we            = 1'b0;
    st_waddr         = cur_q;
    st_wdata         = SLOT_EMPTY;
    if (cmd_i.decode && (dec_err != ERR_OK)) begin
      emit_vld     = 1'b1;
      emit_res.err = dec_err;
    end
    if (cmd_i.main) begin
      emit_vld         = main_w2;
      emit_res.command = CMD_LOAD;
      emit_res.slot    = n_q;
      emit_res.w1      = main_w1;
      emit_res.w2      = main_w2;
      st_we            = 1'b1;
      st_waddr         = n_idx;
      st_wdata         = SLOT_LOADED;
    end
    if (cmd_i.prefetch && scan_live && (cur_st == SLOT_EMPTY)) begin
      emit_vld         = 1'b1;
      emit_res.command = CMD_LOAD;
      emit_res.slot    = SLOT_W'(cur_q);
      st_we            = 1'b1;
      st_wdata         = SLOT_LOADING;
    end
    if (cmd_i.sweep && scan_live) begin
      if (op_q == OP_PRELOAD) begin
        emit_vld      = 1'b1;
        emit_res.slot = SLOT_W'(cur_q);
        if (cur_st == SLOT_EMPTY) begin
          emit_res.command = CMD_LOAD;
          st_we            = 1'b1;
          st_wdata         = SLOT_LOADING;
        end else begin
          emit_res.err = ERR_PRELOAD_BUSY;
        end
      end else if (cur_st != SLOT_EMPTY) begin
        emit_vld         = 1'b1;
        emit_res.command = CMD_UNLOAD;
        emit_res.slot    = SLOT_W'(cur_q);
        st_we            = 1'b1;
        st_wdata         = SLOT_EMPTY;
      end
    end
    if (cmd_i.unload && unload_ok) begin
      emit_vld         = 1'b1;
      emit_res.command = CMD_UNLOAD;
      emit_res.slot    = SLOT_W'(prev_q);
      st_we            = 1'b1;
      st_waddr         = prev_idx;
      st_wdata         = SLOT_UNLOADING;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      desc_q       <= 1'b0;
      prev_q       <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        st_q[i] <= SLOT_EMPTY;
      end
    end else begin
      if (st_we) begin
        st_q[st_waddr] <= st_wdata;
      end
      if (cmd_i.decode) begin
        if ((op_q == OP_REQUEST) && (dec == DEC_MAIN) && !started_q) begin
          started_q <= 1'b1;
          desc_q    <= eff_desc;
          prev_q    <= eff_desc ? PW'(s_c) : PW'(MINUS1_C);
        end
        if ((op_q == OP_PRELOAD) && !started_q) begin
          started_q <= 1'b1;
          desc_q    <= down_q;
          prev_q    <= down_q ? PW'(s_c) : PW'(MINUS1_C);
        end
        if ((op_q == OP_CLEAR) && started_q) begin
          started_q <= 1'b0;
          prev_q    <= '0;
        end
      end
      if (cmd_i.unload) begin
        if (!desc_q) begin
          if (n_c == s_c - ONE_C) begin
            desc_q <= 1'b1;
            prev_q <= PW'(s_c);
          end else begin
            prev_q <= PW'(n_c);
          end
        end else begin
          if (n_c == ZERO_C) begin
            desc_q <= 1'b0;
            prev_q <= PW'(MINUS1_C);
          end else begin
            prev_q <= PW'(n_c);
          end
        end
      end
      // result staging flags
      if (emit_vld) begin
        pend_valid_q <= 1'b1;
        res_valid_q  <= pend_valid_q;
      end else if (cmd_i.finish) begin
        pend_valid_q <= 1'b0;
        res_valid_q  <= 1'b1;
      end else begin
        res_valid_q  <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(operation_i);
      n_q    <= slot_index_i;
      down_q <= preload_downward_i;
      w1_q   <= 1'b0;
      w2_q   <= 1'b0;
    end
    if (cmd_i.decode) begin
      cur_q <= IW'(cur_init);
      rem_q <= SCW'(rem_init);
    end
    if (cmd_i.main) begin
      w1_q <= main_w1;
      w2_q <= main_w2;
    end
    if ((cmd_i.prefetch || cmd_i.sweep) && scan_live) begin
      cur_q <= desc_q ? (cur_q - IW'(1)) : (cur_q + IW'(1));
      rem_q <= rem_q - SCW'(1);
    end
    if (emit_vld) begin
      pend_q     <= emit_res;
      res_q      <= pend_q;
      res_last_q <= 1'b0;
    end else if (cmd_i.finish) begin
      res_last_q <= 1'b1;
      if (pend_valid_q) begin
        res_q <= pend_q;
      end else begin
        res_q.command <= CMD_NONE;
        res_q.slot    <= '0;
        res_q.err     <= ERR_OK;
        res_q.w1      <= w1_q;
        res_q.w2      <= w2_q;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign res_last_o  = res_last_q;

endmodule

// File: design/prefetch_window_slot_manager.sv
// ----------------------------------------------------------------------------
// prefetch_window_slot_manager
// load/unload planner for a row of buffer slots walked by an up/down sweep
// ----------------------------------------------------------------------------
// usage
//   transaction in: start_i with operation_i (request, preload, clear),
//     slot_index_i and preload_downward_i; taken when start_i is high and
//     busy_o is low. busy_o stays high until the transaction is done
//   results: one per load/unload command, each on the result ports for one
//     cycle with result_valid_o; last_of_run_o marks the final one. a
//     transaction that issues no command gives a single result with command 0
//   the receiver cannot stall: every result is taken in the cycle it shows
//   config: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; ready is
//     always high, write only while busy_o is low
//   timing: the slot scan visits one slot per cycle through a single read of
//     the slot state array. busy_o is high through decode, requested slot,
//     window scan (window = prefetched slots beyond the requested one, up to
//     31), unload, finish for an accepted request; decode, sweep, finish for
//     a preload or two-pass clear; decode, finish for anything else, rejected
//     requests included; last result strobes in the first cycle busy_o is low
//   reset: all slots empty, no sweep started, slots_in_use 32, lookahead 1,
//     two_pass_mode 0
// ----------------------------------------------------------------------------
module prefetch_window_slot_manager import pwsm_pkg::*; #(
  parameter int MAX_SLOTS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // transaction in
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            operation_i,
  input  logic [SLOT_W-1:0]     slot_index_i,
  input  logic                  preload_downward_i,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // results
  output logic                  result_valid_o,
  output logic [1:0]            command_o,
  output logic [SLOT_W-1:0]     target_slot_o,
  output logic [2:0]            error_code_o,
  output logic                  warn_was_unloading_o,
  output logic                  warn_not_prefetched_o,
  output logic                  last_of_run_o
);

  // configuration registers
  logic [SIZE_W-1:0] slots_in_use_q;
  logic [LOOK_W-1:0] lookahead_q;
  logic              two_pass_q;

  // controller/datapath link
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;
  result_t    res;
  logic       res_valid;
  logic       res_last;

  // config port never back-pressures
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= SLOTS_RESET_C;
      lookahead_q    <= LOOK_RESET_C;
      two_pass_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SLOTS:     slots_in_use_q <= cfg_data_i;
        CFG_LOOKAHEAD: lookahead_q    <= cfg_data_i[LOOK_W-1:0];
        CFG_TWO_PASS:  two_pass_q     <= cfg_data_i[0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  // sequencer: decode, then requested slot, window scan and unload, or a sweep, then finish
  pwsm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (dp_status),
    .busy_o   (busy_o),
    .cmd_o    (ctrl_cmd)
  );

  // slot state array, sweep position and result staging
  pwsm_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (ctrl_cmd),
    .operation_i        (operation_i),
    .slot_index_i       (slot_index_i),
    .preload_downward_i (preload_downward_i),
    .cfg_slots_i        (slots_in_use_q),
    .cfg_lookahead_i    (lookahead_q),
    .cfg_two_pass_i     (two_pass_q),
    .status_o           (dp_status),
    .res_valid_o        (res_valid),
    .res_o              (res),
    .res_last_o         (res_last)
  );

  // result ports straight from the output register
  assign result_valid_o        = res_valid;
  assign command_o             = res.command;
  assign target_slot_o         = res.slot;
  assign error_code_o          = res.err;
  assign warn_was_unloading_o  = res.w1;
  assign warn_not_prefetched_o = res.w2;
  assign last_of_run_o         = res_last;

endmodule
